// ----- hdl/uidf_pkg.sv -----
`timescale 1ns / 1ps

package uidf_pkg;

    // Field widths of the request and result channels.
    localparam int ID_W      = 18;   // inverse depth, unsigned Q2.16
    localparam int HESS_W    = 32;   // hessian, unsigned Q24.8
    localparam int GATE_W    = 16;   // chi-square gate, unsigned Q8.8
    localparam int FCNT_W    = 3;    // fused child count
    localparam int CFG_IDX_W = 1;    // configuration register index

    // Derived datapath widths.
    localparam int DEN_W      = HESS_W + 1;            // sum of two hessians
    localparam int D2_W       = 2 * ID_W;              // squared depth difference, Q4.32
    localparam int SQ_W       = ID_W + 1 + ID_W;       // squaring unit product
    localparam int NUM_W      = HESS_W + 1 + ID_W;     // weighted idepth numerator
    localparam int GPROD_W    = DEN_W + 1 + D2_W;      // gate product d^2 * H
    localparam int GATE_SHIFT = 32;                    // aligns Q8.8 gate with Q4.32 * Q24.8

    localparam logic [GATE_W-1:0] GATE_GOOD_RST = 16'd1533;  // 5.99
    localparam logic [GATE_W-1:0] GATE_BAD_RST  = 16'd983;   // 3.84

    localparam logic [FCNT_W-1:0] FCNT_MAX = 3'd7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_GOOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_BAD  = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_A,
        S_RUN_A,
        S_LOAD_B,
        S_RUN_B,
        S_FINISH,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic start_a;
        logic start_b;
        logic finish;
        logic emit;
    } t_ctrl;

endpackage

// ----- hdl/uidf_req_if.sv -----
`timescale 1ns / 1ps

interface uidf_req_if;
    logic                        valid;
    logic                        ready;
    logic [uidf_pkg::ID_W-1:0]   target_idepth;
    logic [uidf_pkg::HESS_W-1:0] target_hessian;
    logic                        target_good;
    logic [uidf_pkg::ID_W-1:0]   child_idepth;
    logic [uidf_pkg::HESS_W-1:0] child_hessian;
    logic                        child_good;
    logic                        last_child;

    modport source (
        output valid, target_idepth, target_hessian, target_good,
               child_idepth, child_hessian, child_good, last_child,
        input  ready
    );

    modport sink (
        input  valid, target_idepth, target_hessian, target_good,
               child_idepth, child_hessian, child_good, last_child,
        output ready
    );
endinterface

// ----- hdl/uidf_rsp_if.sv -----
`timescale 1ns / 1ps

interface uidf_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [uidf_pkg::ID_W-1:0]   out_idepth;
    logic [uidf_pkg::HESS_W-1:0] new_hessian;
    logic                        new_good;
    logic [uidf_pkg::FCNT_W-1:0] fused_count;
    logic                        was_updated;

    modport source (
        output valid, out_idepth, new_hessian, new_good, fused_count, was_updated,
        input  ready
    );

    modport sink (
        input  valid, out_idepth, new_hessian, new_good, fused_count, was_updated,
        output ready
    );
endinterface

// ----- hdl/uidf_mac_serial.sv -----
`timescale 1ns / 1ps

// Bit-serial multiply-accumulate: product = mcand_a * mplr_a + mcand_b * mplr_b.
// One multiplier bit of each pair is consumed per cycle; the low product bits
// shift into the vacated top of the first multiplier register.
module uidf_mac_serial #(
    parameter int MCAND_W = 32,
    parameter int MPLR_W  = 18
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [MCAND_W-1:0]        i_mcand_a,
    input  logic [MPLR_W-1:0]         i_mplr_a,
    input  logic [MCAND_W-1:0]        i_mcand_b,
    input  logic [MPLR_W-1:0]         i_mplr_b,
    output logic                      o_busy,
    output logic [MCAND_W+MPLR_W:0]   o_product
);

    localparam int CNT_W = $clog2(MPLR_W + 1);
    localparam logic [CNT_W-1:0] STEPS     = CNT_W'(MPLR_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(1);

    logic               r_busy;
    logic [CNT_W-1:0]   r_count;
    logic [MCAND_W:0]   r_acc;
    logic [MCAND_W-1:0] r_mcand_a;
    logic [MCAND_W-1:0] r_mcand_b;
    logic [MPLR_W-1:0]  r_mplr_a;
    logic [MPLR_W-1:0]  r_mplr_b;

    logic [MCAND_W+1:0] add_a;
    logic [MCAND_W+1:0] add_b;
    logic [MCAND_W+1:0] sum;

    assign add_a = r_mplr_a[0] ? {2'b00, r_mcand_a} : '0;
    assign add_b = r_mplr_b[0] ? {2'b00, r_mcand_b} : '0;
    assign sum   = {1'b0, r_acc} + add_a + add_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_count <= STEPS;
        end else if (r_busy) begin
            r_count <= r_count - LAST_STEP;
            if (r_count == LAST_STEP) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc     <= '0;
            r_mcand_a <= i_mcand_a;
            r_mcand_b <= i_mcand_b;
            r_mplr_a  <= i_mplr_a;
            r_mplr_b  <= i_mplr_b;
        end else if (r_busy) begin
            r_acc    <= sum[MCAND_W+1:1];
            r_mplr_a <= {sum[0], r_mplr_a[MPLR_W-1:1]};
            r_mplr_b <= {1'b0, r_mplr_b[MPLR_W-1:1]};
        end
    end

    assign o_busy    = r_busy;
    assign o_product = {r_acc, r_mplr_a};

endmodule

// ----- hdl/uidf_div_serial.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The caller guarantees
// num < den * 2^QUO_W, so the quotient fits QUO_W bits and the upper part of
// the dividend is already a valid partial remainder.
module uidf_div_serial #(
    parameter int DEN_W = 33,
    parameter int QUO_W = 18
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [DEN_W+QUO_W-1:0]  i_num,
    input  logic [DEN_W-1:0]        i_den,
    output logic                    o_busy,
    output logic [QUO_W-1:0]        o_quo
);

    localparam int CNT_W = $clog2(QUO_W + 1);
    localparam logic [CNT_W-1:0] STEPS     = CNT_W'(QUO_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(1);

    logic               r_busy;
    logic [CNT_W-1:0]   r_count;
    logic [DEN_W-1:0]   r_rem;
    logic [DEN_W-1:0]   r_den;
    logic [QUO_W-1:0]   r_shift;

    logic [DEN_W:0]     trial;
    logic [DEN_W:0]     diff;
    logic               fits;

    assign trial = {r_rem, r_shift[QUO_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_count <= STEPS;
        end else if (r_busy) begin
            r_count <= r_count - LAST_STEP;
            if (r_count == LAST_STEP) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= i_num[DEN_W+QUO_W-1:QUO_W];
            r_shift <= i_num[QUO_W-1:0];
            r_den   <= i_den;
        end else if (r_busy) begin
            r_rem   <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_shift <= {r_shift[QUO_W-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_shift;

endmodule

// ----- hdl/upward_inverse_depth_fusion_unit.sv -----
// Channel   Direction  Port    Payload
// request   in         i_req   target idepth/hessian/good, child idepth/hessian/good, last
// result    out        o_rsp   new idepth/hessian/good, fused count, updated flag
// config    in         i_cfg_* write enable, register index, 16-bit gate value
//
// A request whose child is tested against the gate goes, after acceptance, through a load
// step, the serial squaring and numerator products, a second load step, the bit-serial gate
// product d^2 * H (the divider runs alongside it) and a finish step before the next ready.
// A request with a skipped child goes straight to the finish step. One that closes its group
// adds an emit step to load the result register, and waits there while it is still full.
// Reset is synchronous and active low; it clears the sequencer, group bookkeeping, the
// result valid flag and restores both gates to their defaults.
`timescale 1ns / 1ps

module upward_inverse_depth_fusion_unit #(
    parameter int MAX_CHILDREN = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    uidf_req_if.sink                         i_req,
    uidf_rsp_if.source                       o_rsp,
    input  logic                             i_cfg_we,
    input  logic [uidf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [uidf_pkg::GATE_W-1:0]      i_cfg_wdata
);

    localparam int ID_W    = uidf_pkg::ID_W;
    localparam int HESS_W  = uidf_pkg::HESS_W;
    localparam int DEN_W   = uidf_pkg::DEN_W;
    localparam int D2_W    = uidf_pkg::D2_W;
    localparam int SQ_W    = uidf_pkg::SQ_W;
    localparam int NUM_W   = uidf_pkg::NUM_W;
    localparam int GPROD_W = uidf_pkg::GPROD_W;
    localparam int FCNT_W  = uidf_pkg::FCNT_W;

    // The seen-children counter must be able to hold MAX_CHILDREN itself.
    localparam int SEEN_W = $clog2(MAX_CHILDREN + 1);
    localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_CHILDREN);

    // Configuration registers.
    logic [uidf_pkg::GATE_W-1:0] r_gate_good;
    logic [uidf_pkg::GATE_W-1:0] r_gate_bad;

    // Sequencer and group bookkeeping.
    uidf_pkg::t_state r_state;
    uidf_pkg::t_state n_state;
    uidf_pkg::t_ctrl  ctrl;
    logic               r_group_open;
    logic [SEEN_W-1:0]  r_child_seen;
    logic [FCNT_W-1:0]  r_accept_count;
    logic               r_sticky;

    // Latched request fields.
    logic               r_try;
    logic               r_last;
    logic [ID_W-1:0]    r_ti;
    logic [HESS_W-1:0]  r_th;
    logic               r_tg;
    logic [ID_W-1:0]    r_ci;
    logic [HESS_W-1:0]  r_ch;

    // Running fusion state.
    logic [ID_W-1:0]    r_run_idepth;
    logic [HESS_W-1:0]  r_run_hessian;

    // Result register.
    logic               r_out_valid;
    logic [ID_W-1:0]    r_out_idepth;
    logic [HESS_W-1:0]  r_new_hessian;
    logic               r_new_good;
    logic [FCNT_W-1:0]  r_fused_count;
    logic               r_was_updated;

    // Datapath wires.
    logic               req_fire;
    logic [SEEN_W-1:0]  seen_base;
    logic               child_room;
    logic               req_try;
    logic               out_space;
    logic               load_out;
    logic [ID_W-1:0]    depth_diff;
    logic [SQ_W-1:0]    sq_prod;
    logic [D2_W-1:0]    d2;
    logic [NUM_W-1:0]   num_prod;
    logic [GPROD_W-1:0] gate_prod;
    logic [GPROD_W-1:0] gate_lim;
    logic [uidf_pkg::GATE_W-1:0] gate_sel;
    logic [DEN_W-1:0]   gate_hess;
    logic [DEN_W-1:0]   den;
    logic               den_zero;
    logic [NUM_W-1:0]   div_num;
    logic [ID_W-1:0]    div_quo;
    logic [HESS_W-1:0]  hess_sat;
    logic               fuse_pass;
    logic               fused;
    logic               sq_busy;
    logic               num_busy;
    logic               gate_busy;
    logic               div_busy;

    // ------------------------------------------------------------------
    // Request acceptance. The first request of a group seeds the running
    // values; only the first MAX_CHILDREN children of a group are tested.
    // ------------------------------------------------------------------
    assign req_fire   = i_req.valid && ctrl.in_ready;
    assign seen_base  = r_group_open ? r_child_seen : '0;
    assign child_room = seen_base < SEEN_MAX;
    assign req_try    = child_room && i_req.child_good;
    assign i_req.ready = ctrl.in_ready;

    assign out_space = !r_out_valid || o_rsp.ready;
    assign load_out  = ctrl.emit && out_space;

    // ------------------------------------------------------------------
    // Arithmetic. The depth difference is squared serially while the
    // weighted numerator run_idepth*run_hessian + ci*ch is formed. Then the
    // gate product d^2 * H is formed serially while the divider rounds
    // (num + den/2) / den.
    // ------------------------------------------------------------------
    assign depth_diff = (r_ti >= r_ci) ? (r_ti - r_ci) : (r_ci - r_ti);
    assign d2         = sq_prod[D2_W-1:0];

    assign gate_hess = r_tg ? ({1'b0, r_th} + {1'b0, r_ch}) : {1'b0, r_ch};
    assign gate_sel  = r_tg ? r_gate_good : r_gate_bad;
    assign gate_lim  = GPROD_W'(gate_sel) << uidf_pkg::GATE_SHIFT;

    assign den      = {1'b0, r_run_hessian} + {1'b0, r_ch};
    assign den_zero = (den == '0);
    assign div_num  = num_prod + NUM_W'(den[DEN_W-1:1]);
    assign hess_sat = den[DEN_W-1] ? '1 : den[HESS_W-1:0];

    // A zero gate gives a zero limit, so the strict compare rejects everything.
    assign fuse_pass = r_try && (gate_prod < gate_lim);
    assign fused     = !r_sticky && (r_accept_count != '0);

    uidf_mac_serial #(
        .MCAND_W (ID_W),
        .MPLR_W  (ID_W)
    ) u_sq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (ctrl.start_a),
        .i_mcand_a (depth_diff),
        .i_mplr_a  (depth_diff),
        .i_mcand_b ('0),
        .i_mplr_b  ('0),
        .o_busy    (sq_busy),
        .o_product (sq_prod)
    );

    uidf_mac_serial #(
        .MCAND_W (HESS_W),
        .MPLR_W  (ID_W)
    ) u_num (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (ctrl.start_a),
        .i_mcand_a (r_run_hessian),
        .i_mplr_a  (r_run_idepth),
        .i_mcand_b (r_ch),
        .i_mplr_b  (r_ci),
        .o_busy    (num_busy),
        .o_product (num_prod)
    );

    uidf_mac_serial #(
        .MCAND_W (DEN_W),
        .MPLR_W  (D2_W)
    ) u_gate (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (ctrl.start_b),
        .i_mcand_a (gate_hess),
        .i_mplr_a  (d2),
        .i_mcand_b ('0),
        .i_mplr_b  ('0),
        .o_busy    (gate_busy),
        .o_product (gate_prod)
    );

    // The weighted mean never exceeds the larger input idepth, so the
    // rounded quotient always fits the idepth width.
    uidf_div_serial #(
        .DEN_W (DEN_W),
        .QUO_W (ID_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctrl.start_b && !den_zero),
        .i_num   (div_num),
        .i_den   (den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            uidf_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_state = req_try ? uidf_pkg::S_LOAD_A : uidf_pkg::S_FINISH;
                end
            end
            uidf_pkg::S_LOAD_A: begin
                n_state = uidf_pkg::S_RUN_A;
            end
            uidf_pkg::S_RUN_A: begin
                if (!sq_busy && !num_busy) begin
                    n_state = uidf_pkg::S_LOAD_B;
                end
            end
            uidf_pkg::S_LOAD_B: begin
                n_state = uidf_pkg::S_RUN_B;
            end
            uidf_pkg::S_RUN_B: begin
                if (!gate_busy && !div_busy) begin
                    n_state = uidf_pkg::S_FINISH;
                end
            end
            uidf_pkg::S_FINISH: begin
                n_state = r_last ? uidf_pkg::S_EMIT : uidf_pkg::S_IDLE;
            end
            uidf_pkg::S_EMIT: begin
                if (out_space) begin
                    n_state = uidf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = uidf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl = '0;
        unique case (r_state)
            uidf_pkg::S_IDLE:   ctrl.in_ready = 1'b1;
            uidf_pkg::S_LOAD_A: ctrl.start_a  = 1'b1;
            uidf_pkg::S_LOAD_B: ctrl.start_b  = 1'b1;
            uidf_pkg::S_FINISH: ctrl.finish   = 1'b1;
            uidf_pkg::S_EMIT:   ctrl.emit     = 1'b1;
            default:            ctrl          = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control state.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= uidf_pkg::S_IDLE;
            r_gate_good    <= uidf_pkg::GATE_GOOD_RST;
            r_gate_bad     <= uidf_pkg::GATE_BAD_RST;
            r_group_open   <= 1'b0;
            r_child_seen   <= '0;
            r_accept_count <= '0;
            r_sticky       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    uidf_pkg::CFG_GATE_GOOD: r_gate_good <= i_cfg_wdata;
                    uidf_pkg::CFG_GATE_BAD:  r_gate_bad  <= i_cfg_wdata;
                    default:                 r_gate_bad  <= r_gate_bad;
                endcase
            end

            if (req_fire) begin
                r_group_open <= 1'b1;
                r_child_seen <= seen_base + SEEN_W'(child_room);
                if (!r_group_open) begin
                    r_accept_count <= '0;
                    r_sticky       <= 1'b0;
                end
            end

            // A passing child with a zero denominator poisons the group.
            if (ctrl.finish && fuse_pass) begin
                if (den_zero) begin
                    r_sticky <= 1'b1;
                end
                if (r_accept_count != uidf_pkg::FCNT_MAX) begin
                    r_accept_count <= r_accept_count + FCNT_W'(1);
                end
            end

            if (load_out) begin
                r_group_open <= 1'b0;
                r_out_valid  <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_ti   <= i_req.target_idepth;
            r_th   <= i_req.target_hessian;
            r_tg   <= i_req.target_good;
            r_ci   <= i_req.child_idepth;
            r_ch   <= i_req.child_hessian;
            r_try  <= req_try;
            r_last <= i_req.last_child;
            if (!r_group_open) begin
                r_run_idepth  <= i_req.target_good ? i_req.target_idepth  : '0;
                r_run_hessian <= i_req.target_good ? i_req.target_hessian : '0;
            end
        end

        // The hessian accumulates even once the group is poisoned; the
        // idepth only moves while the group is still clean.
        if (ctrl.finish && fuse_pass) begin
            r_run_hessian <= hess_sat;
            if (!den_zero && !r_sticky) begin
                r_run_idepth <= div_quo;
            end
        end

        if (load_out) begin
            r_fused_count <= r_accept_count;
            r_out_idepth  <= fused ? r_run_idepth : r_ti;
            r_was_updated <= fused;
            if (fused) begin
                r_new_hessian <= r_run_hessian;
                r_new_good    <= 1'b1;
            end else begin
                r_new_hessian <= r_tg ? r_th : '0;
                r_new_good    <= r_tg;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.out_idepth  = r_out_idepth;
    assign o_rsp.new_hessian = r_new_hessian;
    assign o_rsp.new_good    = r_new_good;
    assign o_rsp.fused_count = r_fused_count;
    assign o_rsp.was_updated = r_was_updated;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == uidf_pkg::S_IDLE) |-> (!sq_busy && !num_busy && !gate_busy && !div_busy))
        else $error("arithmetic unit still busy while waiting for a request");

    a_sticky_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.finish && fuse_pass && den_zero) |=> r_sticky)
        else $error("zero denominator did not mark the group invalid");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_accept_count) <= 32'(r_child_seen)))
        else $error("more children fused than were seen");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == uidf_pkg::S_EMIT))
        else $error("result loaded outside of the emit step");

endmodule
